/* sv/pending_commit_tracker_assert.svh */
// Assertion macros for the pending commit tracker
`ifndef PENDING_COMMIT_TRACKER_ASSERT_SVH
`define PENDING_COMMIT_TRACKER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define PCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/pct_pkg.sv */
// ---------------------------------------------------------------------------
// pct_pkg
// Shared types and constants of the pending commit tracker.
// ---------------------------------------------------------------------------
package pct_pkg;
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [8:0] LEADER_NONE = 9'h1FF;

  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_CLOSE  = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] OC_COMMITTED = 2'd0;
  localparam logic [1:0] OC_LOST      = 2'd1;
  localparam logic [1:0] OC_TIMEOUT   = 2'd2;
  localparam logic [1:0] OC_FULL      = 2'd3;

  localparam int QDEPTH = 2;
  localparam int ODEPTH = 4;

  // Table entry payload
  typedef struct packed {
    logic [15:0] conn;
    logic [30:0] index;
    logic [30:0] term;
    logic [31:0] time_ms;
  } entry_t;
  localparam int ENTRY_W = $bits(entry_t);

  // Classified request passed from front to back
  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] conn;
    logic [30:0] target_index;
    logic [30:0] submit_term;
    logic [30:0] commit_index;
    logic        is_leader;
    logic [30:0] current_term;
    logic [8:0]  leader_id;
    logic [31:0] now_ms;
  } cmd_t;
  localparam int CMD_W = $bits(cmd_t);

  // One result item
  typedef struct packed {
    logic [15:0] conn;
    logic [1:0]  outcome;
    logic [8:0]  leader_id;
    logic        last;
  } res_t;
  localparam int RES_W = $bits(res_t);
endpackage

/* sv/pending_commit_tracker.sv */
// ---------------------------------------------------------------------------
// pending_commit_tracker
// Table of writes waiting to commit, with submit, close and flush requests.
// ---------------------------------------------------------------------------
// A submit is written into the table from idle; close and flush walk the table
// one entry at a time, reading and evaluating each kept entry and, for a removed
// entry, also moving the tail entry into the freed slot; a full result queue
// stalls the walk. The single read port of the entry RAM and the swap-with-tail
// removal set these steps. Results wait in a four-deep queue; items are queued
// two deep in front of the table engine.
module pending_commit_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_conn_id,
  input  logic [30:0] in_target_index,
  input  logic [30:0] in_submit_term,
  input  logic [30:0] in_commit_index,
  input  logic        in_is_leader,
  input  logic [30:0] in_current_term,
  input  logic signed [8:0] in_leader_id,
  input  logic [31:0] in_now_ms,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_result_conn,
  output logic [1:0]  out_outcome,
  output logic signed [8:0] out_reply_leader_id,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_timeout_ms
);
  import pct_pkg::*;

  logic [15:0] timeout_r;
  cmd_t        in_cmd, cmd;
  logic        cmd_valid, cmd_take, res_valid, res_room;
  res_t        res, out_res;

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_timeout_ms;
    end
  end

  assign in_cmd = '{req: in_req_type, conn: in_conn_id, target_index: in_target_index,
                    submit_term: in_submit_term, commit_index: in_commit_index,
                    is_leader: in_is_leader, current_term: in_current_term,
                    leader_id: in_leader_id, now_ms: in_now_ms};

  pct_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  pct_back u_back (
    .clk(clk), .rst_n(rst_n), .timeout_ms(timeout_r), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .cmd(cmd), .res_valid(res_valid), .res_room(res_room), .res(res)
  );

  pct_outq u_outq (
    .clk(clk), .rst_n(rst_n), .res_valid(res_valid), .res_room(res_room), .res(res),
    .out_empty(empty), .out_pop(pop), .out_res(out_res)
  );

  assign out_result_conn     = out_res.conn;
  assign out_outcome         = out_res.outcome;
  assign out_reply_leader_id = out_res.leader_id;
  assign out_last            = out_res.last;
endmodule

/* sv/pct_ram.sv */
// ---------------------------------------------------------------------------
// pct_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/pct_front.sv */
// ---------------------------------------------------------------------------
// pct_front
// Accepts items, drops unused request codes, queues commands for the back end.
// ---------------------------------------------------------------------------
module pct_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  pct_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output pct_pkg::cmd_t cmd
);
  import pct_pkg::*;

  localparam int QW = $clog2(QDEPTH);

  cmd_t          q_r [QDEPTH];
  logic [QW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QW:0]   cnt_r, cnt_nxt;
  logic          acc, keep;

  assign in_full   = (cnt_r == (QW+1)'(QDEPTH));
  assign acc       = in_push && !in_full;
  // Drop the unused request code: it has no effect
  assign keep      = acc && (in_cmd.req != REQ_UNUSED);
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];

  // Advance pointers
  always_comb begin
    wp_nxt  = keep ? wp_r + 1'b1 : wp_r;
    rp_nxt  = (cmd_take && cmd_valid) ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QW+1)'(keep) - (QW+1)'(cmd_take && cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (keep) begin
      q_r[wp_r] <= in_cmd;
    end
  end
endmodule

/* sv/pct_back.sv */
// ---------------------------------------------------------------------------
// pct_back
// Executes commands against the entry table, one entry examined per pass.
// ---------------------------------------------------------------------------
module pct_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   timeout_ms,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  pct_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_room,
  output pct_pkg::res_t res
);
  import pct_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_MOVE = 5'b01000,
    ST_MOVW = 5'b10000
  } state_t;

  state_t             st_r, st_nxt;
  cmd_t               c_r, c_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic               pend_r, pend_nxt;
  res_t               pres_r, pres_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  entry_t             wdata, rdata;

  logic               hit;
  logic [1:0]         oc;
  logic [31:0]        dt;
  logic [CNT_W-1:0]   tail;

  pct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign tail = count_r - 1'b1;
  assign dt   = c_r.now_ms - rdata.time_ms;

  // Classify the entry just read
  always_comb begin
    hit = 1'b0;
    oc  = OC_COMMITTED;
    if (c_r.req == REQ_CLOSE) begin
      hit = (rdata.conn == c_r.conn);
    end else if (rdata.index <= c_r.commit_index) begin
      hit = 1'b1;
    end else if (!c_r.is_leader || rdata.term != c_r.current_term) begin
      hit = 1'b1;
      oc  = OC_LOST;
    end else if (dt > {16'd0, timeout_ms}) begin
      hit = 1'b1;
      oc  = OC_TIMEOUT;
    end
  end

  // Sequencer
  always_comb begin
    st_nxt    = st_r;
    c_nxt     = c_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    pend_nxt  = pend_r;
    pres_nxt  = pres_r;
    cmd_take  = 1'b0;
    res_valid = 1'b0;
    res       = pres_r;
    we        = 1'b0;
    waddr     = IDX_W'(count_r);
    wdata     = '{conn: cmd.conn, index: cmd.target_index,
                  term: cmd.submit_term, time_ms: cmd.now_ms};
    raddr     = IDX_W'(i_r);
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.req == REQ_SUBMIT) begin
            if (count_r < CNT_W'(TABLE_DEPTH)) begin
              cmd_take  = 1'b1;
              we        = 1'b1;
              count_nxt = count_r + 1'b1;
            end else if (res_room) begin
              cmd_take  = 1'b1;
              res_valid = 1'b1;
              res       = '{conn: cmd.conn, outcome: OC_FULL,
                            leader_id: LEADER_NONE, last: 1'b1};
            end
          end else begin
            cmd_take = 1'b1;
            c_nxt    = cmd;
            i_nxt    = '0;
            pend_nxt = 1'b0;
            st_nxt   = ST_RD;
          end
        end
      end
      ST_RD: begin
        // Issue read of entry i, or finish the scan
        if (i_r < count_r) begin
          raddr  = IDX_W'(i_r);
          st_nxt = ST_EVAL;
        end else if (pend_r) begin
          if (res_room) begin
            res_valid = 1'b1;
            res       = pres_r;
            res.last  = 1'b1;
            pend_nxt  = 1'b0;
            st_nxt    = ST_IDLE;
          end
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_EVAL: begin
        if (!hit) begin
          i_nxt  = i_r + 1'b1;
          st_nxt = ST_RD;
        end else if (!pend_r || res_room) begin
          // Emit the previously held result; on a flush, hold this one
          res_valid = pend_r;
          res       = pres_r;
          if (c_r.req == REQ_FLUSH) begin
            pend_nxt = 1'b1;
            pres_nxt = '{conn: rdata.conn, outcome: oc,
                         leader_id: (oc == OC_LOST) ? c_r.leader_id : LEADER_NONE,
                         last: 1'b0};
          end
          count_nxt = tail;
          raddr     = IDX_W'(tail);
          st_nxt    = ST_MOVE;
        end
      end
      ST_MOVE: begin
        // Keep the tail entry on the read port
        raddr  = IDX_W'(count_r);
        st_nxt = ST_MOVW;
      end
      ST_MOVW: begin
        // Swap tail into freed slot and examine it again
        we     = (i_r < count_r);
        waddr  = IDX_W'(i_r);
        wdata  = rdata;
        st_nxt = ST_RD;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    i_r    <= i_nxt;
    pres_r <= pres_nxt;
  end
endmodule

/* sv/pct_outq.sv */
// ---------------------------------------------------------------------------
// pct_outq
// Result queue presented to the consumer.
// ---------------------------------------------------------------------------
module pct_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  output logic          res_room,
  input  pct_pkg::res_t res,
  output logic          out_empty,
  input  logic          out_pop,
  output pct_pkg::res_t out_res
);
  import pct_pkg::*;

  localparam int OW = $clog2(ODEPTH);

  res_t          q_r [ODEPTH];
  logic [OW-1:0] wp_r, rp_r;
  logic [OW:0]   cnt_r, cnt_nxt;
  logic          wr, rd;

  assign res_room  = (cnt_r != (OW+1)'(ODEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_res   = q_r[rp_r];
  assign wr        = res_valid && res_room;
  assign rd        = out_pop && !out_empty;
  assign cnt_nxt   = cnt_r + (OW+1)'(wr) - (OW+1)'(rd);

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wr ? wp_r + 1'b1 : wp_r;
      rp_r  <= rd ? rp_r + 1'b1 : rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= res;
    end
  end
endmodule

/* sv/pct_checker.sv */
// ---------------------------------------------------------------------------
// pct_checker
// Port-level checks of the pending commit tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "pending_commit_tracker_assert.svh"
module pct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_outcome,
  input logic [8:0]  out_reply_leader_id,
  input logic        out_last,
  input logic [15:0] out_result_conn
);
  import pct_pkg::*;

  // A rejected submit is always a lone final result
  `PCT_ASSERT_IMP(a_full_last, clk, rst_n, !empty && out_outcome == OC_FULL, out_last, "full not last")
  // Only lost leadership carries a leader id
  `PCT_ASSERT_IMP(a_lid, clk, rst_n, !empty && out_outcome != OC_LOST, out_reply_leader_id == LEADER_NONE, "leader id")
  // A waiting result holds while not popped
  `PCT_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_result_conn), "result moved")
endmodule

bind pending_commit_tracker pct_checker u_pct_checker (
  .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_outcome(out_outcome),
  .out_reply_leader_id(out_reply_leader_id), .out_last(out_last),
  .out_result_conn(out_result_conn)
);

/* bench/commit_outcome_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// commit_outcome_checker
// Watches the request, result and timeout-register ports of the pending
// commit tracker, keeps its own copy of the pending-write table, works out
// the outcomes of every accepted item and compares them in order with the
// result items the block hands out.
// ---------------------------------------------------------------------------
module commit_outcome_checker
  import pct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_conn_id,
  input  logic [30:0] in_target_index,
  input  logic [30:0] in_submit_term,
  input  logic [30:0] in_commit_index,
  input  logic        in_is_leader,
  input  logic [30:0] in_current_term,
  input  logic [8:0]  in_leader_id,
  input  logic [31:0] in_now_ms,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] out_result_conn,
  input  logic [1:0]  out_outcome,
  input  logic [8:0]  out_reply_leader_id,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_timeout_ms,
  output int          fail_count,
  output int          outcomes_waiting
);

  typedef struct {
    logic [15:0] conn;
    logic [1:0]  outcome;
    logic [8:0]  leader;
    logic        last;
  } outcome_t;

  // Shadow of the pending-write table
  logic [15:0] tbl_conn  [TABLE_DEPTH];
  logic [30:0] tbl_index [TABLE_DEPTH];
  logic [30:0] tbl_term  [TABLE_DEPTH];
  logic [31:0] tbl_time  [TABLE_DEPTH];
  int          tbl_count;
  logic [15:0] limit_ms;
  outcome_t    outcome_q[$];

  assign outcomes_waiting = outcome_q.size();

  // Move the tail entry into the freed slot
  function automatic void drop_entry(int slot);
    tbl_count--;
    tbl_conn[slot]  = tbl_conn[tbl_count];
    tbl_index[slot] = tbl_index[tbl_count];
    tbl_term[slot]  = tbl_term[tbl_count];
    tbl_time[slot]  = tbl_time[tbl_count];
  endfunction

  function automatic void add_outcome(logic [15:0] c, logic [1:0] oc, logic [8:0] lid);
    outcome_t o;
    o.conn = c;
    o.outcome = oc;
    o.leader = lid;
    o.last = 1'b0;
    outcome_q.push_back(o);
  endfunction

  // Apply one request to the table and queue the outcomes it resolves
  function automatic void resolve_request();
    int i;
    int produced;
    logic [31:0] age;
    i = 0;
    produced = 0;
    case (in_req_type)
      REQ_SUBMIT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          add_outcome(in_conn_id, OC_FULL, LEADER_NONE);
          produced = 1;
        end else begin
          tbl_conn[tbl_count]  = in_conn_id;
          tbl_index[tbl_count] = in_target_index;
          tbl_term[tbl_count]  = in_submit_term;
          tbl_time[tbl_count]  = in_now_ms;
          tbl_count++;
        end
      end
      REQ_CLOSE: begin
        while (i < tbl_count) begin
          if (tbl_conn[i] == in_conn_id) drop_entry(i);
          else i++;
        end
      end
      REQ_FLUSH: begin
        while (i < tbl_count) begin
          age = in_now_ms - tbl_time[i];
          if (tbl_index[i] <= in_commit_index) begin
            add_outcome(tbl_conn[i], OC_COMMITTED, LEADER_NONE);
            drop_entry(i);
            produced++;
          end else if (!in_is_leader || tbl_term[i] != in_current_term) begin
            add_outcome(tbl_conn[i], OC_LOST, in_leader_id);
            drop_entry(i);
            produced++;
          end else if (age > {16'd0, limit_ms}) begin
            add_outcome(tbl_conn[i], OC_TIMEOUT, LEADER_NONE);
            drop_entry(i);
            produced++;
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    if (produced > 0) outcome_q[outcome_q.size() - 1].last = 1'b1;
  endfunction

  // Compare results first, then predict from the item taken at the same edge
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst_n) begin
      tbl_count = 0;
      limit_ms = TIMEOUT_RESET;
      fail_count = 0;
      outcome_q.delete();
    end else begin
      if (pop && !empty) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: conn %h outcome %0d leader %h last %b",
                     out_result_conn, out_outcome, out_reply_leader_id, out_last);
        end else begin
          exp_o = outcome_q.pop_front();
          if (exp_o.conn !== out_result_conn || exp_o.outcome !== out_outcome ||
              exp_o.leader !== out_reply_leader_id || exp_o.last !== out_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result differs: exp conn %h oc %0d ldr %h last %b, got %h %0d %h %b",
                       exp_o.conn, exp_o.outcome, exp_o.leader, exp_o.last,
                       out_result_conn, out_outcome, out_reply_leader_id, out_last);
          end
        end
      end
      if (cfg_we) limit_ms = cfg_timeout_ms;
      if (in_push && !in_full) resolve_request();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives submit, close, flush and unused-code items into the pending commit tracker
// under several timeout settings, with random idling on both sides and one
// long result stall that backs the table up; the checker judges the results.
// ---------------------------------------------------------------------------
module tb_top;
  import pct_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_req_type;
  logic [15:0] in_conn_id;
  logic [30:0] in_target_index;
  logic [30:0] in_submit_term;
  logic [30:0] in_commit_index;
  logic        in_is_leader;
  logic [30:0] in_current_term;
  logic [8:0]  in_leader_id;
  logic [31:0] in_now_ms;
  logic        empty;
  logic        pop;
  logic [15:0] out_result_conn;
  logic [1:0]  out_outcome;
  logic [8:0]  out_reply_leader_id;
  logic        out_last;
  logic        cfg_we;
  logic [15:0] cfg_timeout_ms;
  int          fail_count;
  int          outcomes_waiting;

  // Stimulus shaping state
  logic        quiet;
  int          hold_cycles;
  logic [15:0] cur_timeout;
  logic [30:0] log_base;
  logic [30:0] leader_term;
  logic [31:0] wall_ms;

  pending_commit_tracker dut (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_conn_id,
    .in_target_index, .in_submit_term, .in_commit_index, .in_is_leader,
    .in_current_term, .in_leader_id, .in_now_ms, .empty, .pop,
    .out_result_conn, .out_outcome, .out_reply_leader_id, .out_last,
    .cfg_we, .cfg_timeout_ms
  );

  commit_outcome_checker chk (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_conn_id,
    .in_target_index, .in_submit_term, .in_commit_index, .in_is_leader,
    .in_current_term, .in_leader_id, .in_now_ms, .empty, .pop,
    .out_result_conn, .out_outcome, .out_reply_leader_id, .out_last,
    .cfg_we, .cfg_timeout_ms, .fail_count, .outcomes_waiting
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop
  initial begin
    #(20 * 1000000);
    $display("pending_commit_tracker: mismatch");
    $finish;
  end

  // Result side: long hold on request, else random stall bursts
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      hold_cycles <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  // Offer one item and hold it until taken; push stays high afterwards
  task automatic send_item(logic [1:0] rt, logic [15:0] c, logic [30:0] ti,
                           logic [30:0] st, logic [30:0] ci, logic ld,
                           logic [30:0] ct, logic [8:0] lid, logic [31:0] nw);
    @(negedge clk);
    in_push <= 1'b1;
    in_req_type <= rt;
    in_conn_id <= c;
    in_target_index <= ti;
    in_submit_term <= st;
    in_commit_index <= ci;
    in_is_leader <= ld;
    in_current_term <= ct;
    in_leader_id <= lid;
    in_now_ms <= nw;
    // Full only changes at the rising edge, so judge it at the falling one
    while (in_full) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop push, wait for all outcomes, then let the table walk settle
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    wait (outcomes_waiting == 0);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_timeout_ms <= v;
    cur_timeout = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic around a moving log position and clock
  task automatic random_item();
    int pick;
    int n;
    logic [15:0] c;
    logic [31:0] nw;
    pick = $urandom_range(0, 99);
    c = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      @(negedge clk);
      in_push <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    wall_ms = wall_ms + $urandom_range(0, 60);
    if (pick < 50) begin
      send_item(REQ_SUBMIT, c, log_base + 31'($urandom_range(0, 60)),
                ($urandom_range(0, 7) == 0) ? leader_term + 31'd1 : leader_term,
                31'($urandom), 1'($urandom), 31'($urandom), 9'($urandom), wall_ms);
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0: nw = wall_ms + $urandom_range(0, 100);
        1: nw = wall_ms + {16'd0, cur_timeout} + $urandom_range(0, 200) - 32'd100;
        default: nw = $urandom;
      endcase
      if ($urandom_range(0, 9) == 0) leader_term = leader_term + 31'd1;
      send_item(REQ_FLUSH, c, 31'($urandom), 31'($urandom),
                log_base + 31'($urandom_range(0, 30)), $urandom_range(0, 5) != 0,
                leader_term, ($urandom_range(0, 3) == 0) ? LEADER_NONE : 9'($urandom),
                nw);
      log_base = log_base + 31'($urandom_range(0, 20));
      wall_ms = nw;
    end else if (pick < 85) begin
      send_item(REQ_CLOSE, c, 31'($urandom), 31'($urandom), 31'($urandom),
                1'($urandom), 31'($urandom), 9'($urandom), $urandom);
    end else begin
      send_item(2'($urandom_range(0, 3)), 16'($urandom), 31'($urandom), 31'($urandom),
                31'($urandom), 1'($urandom), 31'($urandom), 9'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [15:0] settings [5];
    in_push = 1'b0;
    in_req_type = REQ_SUBMIT;
    in_conn_id = '0;
    in_target_index = '0;
    in_submit_term = '0;
    in_commit_index = '0;
    in_is_leader = 1'b0;
    in_current_term = '0;
    in_leader_id = '0;
    in_now_ms = '0;
    cfg_we = 1'b0;
    cfg_timeout_ms = '0;
    quiet = 1'b0;
    hold_cycles = 0;
    cur_timeout = TIMEOUT_RESET;
    log_base = 31'($urandom);
    leader_term = 31'($urandom);
    wall_ms = $urandom;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, all request types, reset timeout
    send_item(REQ_SUBMIT, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, '0, 1'b0, '0, '0,
              32'hFFFFFFFF);
    send_item(REQ_SUBMIT, 16'h0000, '0, '0, 31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF,
              LEADER_NONE, '0);
    send_item(REQ_UNUSED, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1,
              31'h7FFFFFFF, 9'h0FE, 32'hFFFFFFFF);
    send_item(REQ_FLUSH, '0, '0, '0, '0, 1'b1, '0, 9'h0FE, '0);
    send_item(REQ_FLUSH, '0, '0, '0, '0, 1'b1, '0, 9'h0FE, '0);
    send_item(REQ_SUBMIT, 16'd5, 31'd50, 31'd7, '0, 1'b0, '0, '0, 32'd10);
    send_item(REQ_SUBMIT, 16'd6, 31'd51, 31'd7, '0, 1'b0, '0, '0, 32'd10);
    send_item(REQ_SUBMIT, 16'd5, 31'd52, 31'd7, '0, 1'b0, '0, '0, 32'd10);
    send_item(REQ_CLOSE, 16'd5, '0, '0, '0, 1'b0, '0, '0, '0);
    send_item(REQ_FLUSH, '0, '0, '0, 31'd10, 1'b1, 31'd7, LEADER_NONE, 32'd3010);
    send_item(REQ_FLUSH, '0, '0, '0, 31'd10, 1'b1, 31'd7, LEADER_NONE, 32'd3011);
    send_item(REQ_SUBMIT, 16'd9, 31'd100, 31'd7, '0, 1'b0, '0, '0, 32'hFFFFF000);
    send_item(REQ_SUBMIT, 16'd10, 31'd100, 31'd8, '0, 1'b0, '0, '0, 32'hFFFFF000);
    send_item(REQ_FLUSH, '0, '0, '0, 31'd0, 1'b1, 31'd7, 9'd3, 32'h00000100);
    send_item(REQ_FLUSH, '0, '0, '0, 31'h7FFFFFFF, 1'b0, '0, '0, '0);
    settle();

    // Timeout of zero: any positive age times out
    write_timeout(16'd0);
    send_item(REQ_SUBMIT, 16'd1, 31'd9, 31'd4, '0, 1'b0, '0, '0, 32'd500);
    send_item(REQ_SUBMIT, 16'd2, 31'd9, 31'd4, '0, 1'b0, '0, '0, 32'd501);
    send_item(REQ_FLUSH, '0, '0, '0, 31'd0, 1'b1, 31'd4, '0, 32'd501);
    send_item(REQ_FLUSH, '0, '0, '0, 31'd0, 1'b1, 31'd4, '0, 32'd502);
    settle();

    // Fill the table while results are held back
    hold_cycles = 600;
    send_item(REQ_FLUSH, '0, '0, '0, 31'h7FFFFFFF, 1'b1, '0, '0, '0);
    for (int k = 0; k < 40; k++)
      send_item(REQ_SUBMIT, 16'($urandom), 31'($urandom), 31'($urandom), '0, 1'b0,
                '0, '0, $urandom);
    send_item(REQ_FLUSH, '0, '0, '0, 31'($urandom), $urandom_range(0, 1) == 1,
              31'($urandom), 9'($urandom), $urandom);
    settle();

    // Random phases over several timeout settings, the last without idling
    settings[0] = 16'd1;
    settings[1] = 16'hFFFF;
    settings[2] = 16'($urandom_range(1, 65535));
    settings[3] = TIMEOUT_RESET;
    settings[4] = 16'd100;
    for (int p = 0; p < 5; p++) begin
      write_timeout(settings[p]);
      if (p == 4) quiet = 1'b1;
      for (int k = 0; k < 60; k++) random_item();
      send_item(REQ_FLUSH, '0, '0, '0, 31'h7FFFFFFF, 1'b1, '0, '0, '0);
      settle();
    end

    if (fail_count == 0) begin
      $display("pending_commit_tracker: match");
    end else begin
      $display("pending_commit_tracker: mismatch");
    end
    $finish;
  end

endmodule
